[hdl/sasc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sasc_pkg: shared types and constants of the set-associative LRU cache core
// Geometry limits, derived widths, result codes, register indexes and the
// sequencer states used by the core.
// ----------------------------------------------------------------------------
package sasc_pkg;

  // Geometry limits
  localparam int unsigned MAX_SET_BITS = 6;
  localparam int unsigned MAX_WAYS     = 8;
  localparam int unsigned ADDR_WIDTH   = 48;

  // Derived sizes
  localparam int unsigned NUM_SETS = 1 << MAX_SET_BITS;
  localparam int unsigned SET_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int unsigned SB_W     = (MAX_SET_BITS > 0) ? $clog2(MAX_SET_BITS + 1) : 1;
  localparam int unsigned CNT_W    = $clog2(MAX_WAYS + 1);
  localparam int unsigned WAY_IW   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int unsigned TAGS_W   = MAX_WAYS * ADDR_WIDTH;
  localparam int unsigned ROW_W    = TAGS_W + CNT_W;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 5;

  // Register reset values
  localparam logic [2:0] SET_BITS_RST    = 3'd4;
  localparam logic [4:0] OFFSET_BITS_RST = 5'd4;
  localparam logic [3:0] WAYS_RST        = 4'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SET_BITS    = 2'd0,
    CFG_OFFSET_BITS = 2'd1,
    CFG_WAYS_IN_USE = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OUT_HIT   = 2'd0,
    OUT_MISS  = 2'd1,
    OUT_EVICT = 2'd2
  } outcome_e;

  typedef enum logic {
    ST_IDLE,
    ST_LOOKUP
  } state_e;

endpackage : sasc_pkg
`default_nettype wire

[hdl/set_assoc_lru_cache_sim_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_sim_core: tag-only set-associative cache with true LRU
// Splits each request address into offset, set and tag, searches the set in
// recency order, reorders it and reports hit, miss and eviction totals.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake               payload
//  -------  ---------  ----------------------  -------------------------------
//  in       input      in_valid_i / in_stall_o  cmd_i, address_i
//  out      output     out_valid_o / out_stall_i outcome_o, extra_hit_o,
//                                              hit/miss/eviction_total_o
//  cfg      input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
//  For each request the set row (tags in recency order plus the occupancy)
//  is read from the set memory on acceptance, and the LOOKUP state then
//  compares, reorders and writes the row back while loading the result.
//  The set memory has one write port and one read port; requests are taken
//  only in IDLE. Reset clears the per-set valid bits, counters and registers
//  at once; no clearing pass is needed. A stalled result holds the update
//  cycle until the output register frees; one result waits while the next is accepted.
//
module set_assoc_lru_cache_sim_core
  import sasc_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,

  // Configuration writes
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,

  // Access requests
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic                  cmd_i,
  input  wire logic [ADDR_WIDTH-1:0] address_i,

  // Results
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [1:0]                 outcome_o,
  output logic                       extra_hit_o,
  output logic [31:0]                hit_total_o,
  output logic [31:0]                miss_total_o,
  output logic [31:0]                eviction_total_o
);

  // Configuration registers
  logic [2:0] set_bits_q;
  logic [4:0] offset_bits_q;
  logic [3:0] ways_q;

  state_e state_q, state_d;

  logic                  cmd_q;
  logic [SET_W-1:0]      set_q;
  logic [ADDR_WIDTH-1:0] tag_q;
  logic [NUM_SETS-1:0]   row_vld_q;

  logic [31:0] hit_q, miss_q, evict_q;
  logic [31:0] hit_d, miss_d, evict_d;

  logic                  out_valid_q;
  logic [1:0]            outcome_q;
  logic                  extra_hit_q;

  logic accept, done;

  // Address split
  logic [SB_W-1:0]       sb;
  logic [ADDR_WIDTH-1:0] above;
  logic [ADDR_WIDTH-1:0] tag_in;
  logic [SET_W-1:0]      set_in;

  // Lookup
  logic [ROW_W-1:0]      rd_row;
  logic [ROW_W-1:0]      wr_row;
  logic [ADDR_WIDTH-1:0] tag_w   [MAX_WAYS];
  logic [ADDR_WIDTH-1:0] tag_new [MAX_WAYS];
  logic [CNT_W-1:0]      occ, cap, n, keep, lim, occ_new;
  logic [MAX_WAYS-1:0]   hit_vec;
  logic                  found;
  logic [WAY_IW-1:0]     pos;
  logic                  evict;
  outcome_e              outcome;

  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign done        = (state_q == ST_LOOKUP) && (!out_valid_q || !out_stall_i);

  // Take configuration writes; unknown indexes drop
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_bits_q    <= SET_BITS_RST;
      offset_bits_q <= OFFSET_BITS_RST;
      ways_q        <= WAYS_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_SET_BITS:    set_bits_q    <= cfg_data_i[2:0];
        CFG_OFFSET_BITS: offset_bits_q <= cfg_data_i;
        CFG_WAYS_IN_USE: ways_q        <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // Split the incoming address into set and tag
  always_comb begin
    sb     = (int'(set_bits_q) > int'(MAX_SET_BITS)) ? SB_W'(MAX_SET_BITS)
                                                     : SB_W'(set_bits_q);
    above  = address_i >> offset_bits_q;
    tag_in = above >> sb;
    set_in = above[SET_W-1:0] & ~({SET_W{1'b1}} << sb);
  end

  // Capture the request
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_i;
      set_q <= set_in;
      tag_q <= tag_in;
    end
  end

  // Set memory: one row per set, occupancy above the tags
  sasc_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NUM_SETS)
  ) u_set_ram (
    .clk_i   (clk_i),
    .we_i    (done),
    .waddr_i (set_q),
    .wdata_i (wr_row),
    .re_i    (accept),
    .raddr_i (set_in),
    .rdata_o (rd_row)
  );

  // Search the set, reorder it and count
  always_comb begin
    if (ways_q == 4'd0) begin
      cap = CNT_W'(1);
    end else if (int'(ways_q) > int'(MAX_WAYS)) begin
      cap = CNT_W'(MAX_WAYS);
    end else begin
      cap = CNT_W'(ways_q);
    end

    occ = row_vld_q[set_q] ? rd_row[TAGS_W +: CNT_W] : '0;
    n   = (occ > cap) ? cap : occ;

    for (int i = 0; i < MAX_WAYS; i++) begin
      tag_w[i]   = rd_row[i*ADDR_WIDTH +: ADDR_WIDTH];
      hit_vec[i] = (CNT_W'(i) < n) && (tag_w[i] == tag_q);
    end

    // First matching position wins
    found = |hit_vec;
    pos   = '0;
    for (int i = MAX_WAYS - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        pos = WAY_IW'(i);
      end
    end

    keep  = (n < cap) ? n : cap - CNT_W'(1);
    lim   = found ? CNT_W'(pos) : keep;
    evict = !found && !(n < cap);

    // Shift older tags down one place, new tag to the front
    tag_new[0] = tag_q;
    for (int i = 1; i < MAX_WAYS; i++) begin
      tag_new[i] = (CNT_W'(i) <= lim) ? tag_w[i-1] : tag_w[i];
    end

    if (found) begin
      occ_new = occ;
    end else if (n < cap) begin
      occ_new = n + CNT_W'(1);
    end else begin
      occ_new = cap;
    end

    wr_row[TAGS_W +: CNT_W] = occ_new;
    for (int i = 0; i < MAX_WAYS; i++) begin
      wr_row[i*ADDR_WIDTH +: ADDR_WIDTH] = tag_new[i];
    end

    priority if (found) begin
      outcome = OUT_HIT;
    end else if (evict) begin
      outcome = OUT_EVICT;
    end else begin
      outcome = OUT_MISS;
    end

    hit_d   = hit_q + 32'(found) + 32'(cmd_q);
    miss_d  = miss_q + 32'(!found);
    evict_d = evict_q + 32'(evict);
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (accept) state_d = ST_LOOKUP;
      ST_LOOKUP: if (done)   state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Mark written rows, advance counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      hit_q     <= '0;
      miss_q    <= '0;
      evict_q   <= '0;
    end else if (done) begin
      row_vld_q[set_q] <= 1'b1;
      hit_q            <= hit_d;
      miss_q           <= miss_d;
      evict_q          <= evict_d;
    end
  end

  // Output register: load on completion, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      outcome_q   <= outcome;
      extra_hit_q <= cmd_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign outcome_o        = outcome_q;
  assign extra_hit_o      = extra_hit_q;
  assign hit_total_o      = hit_q;
  assign miss_total_o     = miss_q;
  assign eviction_total_o = evict_q;

endmodule : set_assoc_lru_cache_sim_core
`default_nettype wire

[hdl/sasc_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sasc_ram: generic single-write, single-read synchronous RAM
// One write port and one read port; read data is registered and holds its
// value while no read is issued.
// ----------------------------------------------------------------------------
module sasc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write, then register the read word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule : sasc_ram
`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the set-associative LRU cache core
// Sends load and modify requests under a range of geometries, keeps a
// recency-ordered model of every set and checks each result and the running
// hit, miss and eviction totals, with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module tb_top;
  import sasc_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 300000;
  localparam int unsigned RANDOM_PHASES = 12;
  localparam int unsigned PHASE_ITEMS   = 62;
  localparam int unsigned TAG_POOL      = MAX_WAYS + 2;
  // Index with no register behind it; the core must ignore writes to it
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef struct packed {
    outcome_e    outcome;
    logic        extra_hit;
    logic [31:0] hits;
    logic [31:0] misses;
    logic [31:0] evictions;
  } access_result_t;

  // Stimulus side
  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  cmd_i       = 1'b0;
  logic [ADDR_WIDTH-1:0] address_i   = '0;
  logic                  out_stall_i = 1'b0;

  // Core outputs
  logic        cfg_ready_o;
  logic        in_stall_o;
  logic        out_valid_o;
  logic [1:0]  outcome_o;
  logic        extra_hit_o;
  logic [31:0] hit_total_o;
  logic [31:0] miss_total_o;
  logic [31:0] eviction_total_o;

  // Cache model: tags per set in recency order, most recent at way 0
  logic [ADDR_WIDTH-1:0] tag_mem  [NUM_SETS][MAX_WAYS];
  bit                    line_ok  [NUM_SETS][MAX_WAYS];
  int                    set_fill [NUM_SETS];
  logic [31:0]           hit_count   = '0;
  logic [31:0]           miss_count  = '0;
  logic [31:0]           evict_count = '0;
  logic [2:0]            cfg_set_bits    = SET_BITS_RST;
  logic [4:0]            cfg_offset_bits = OFFSET_BITS_RST;
  logic [3:0]            cfg_ways        = WAYS_RST;

  access_result_t pending_outcomes [$];

  int unsigned errors       = 0;
  int unsigned items_sent   = 0;
  int unsigned results_seen = 0;
  int unsigned reg_writes   = 0;
  int unsigned cycle_count  = 0;
  int unsigned stall_hold   = 0;
  bit          calm         = 1'b0;

  set_assoc_lru_cache_sim_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .cmd_i            (cmd_i),
    .address_i        (address_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .outcome_o        (outcome_o),
    .extra_hit_o      (extra_hit_o),
    .hit_total_o      (hit_total_o),
    .miss_total_o     (miss_total_o),
    .eviction_total_o (eviction_total_o)
  );

  // Generate the clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Hold off the result channel: mostly short stalls, now and then a long one
  always @(posedge clk_i) begin
    if (stall_hold != 0) begin
      stall_hold  <= stall_hold - 1;
      out_stall_i <= 1'b1;
    end else if (calm || $urandom_range(0, 99) < 65) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= 1'b1;
      stall_hold  <= ($urandom_range(0, 9) == 0) ? $urandom_range(6, 30) : $urandom_range(0, 2);
    end
  end

  function automatic int eff_set_bits();
    return (cfg_set_bits > MAX_SET_BITS) ? int'(MAX_SET_BITS) : int'(cfg_set_bits);
  endfunction

  function automatic int eff_ways();
    if (cfg_ways == 0) return 1;
    if (cfg_ways > MAX_WAYS) return int'(MAX_WAYS);
    return int'(cfg_ways);
  endfunction

  // Build an address from tag, set and offset under the current geometry
  function automatic logic [ADDR_WIDTH-1:0] compose_addr(input logic [ADDR_WIDTH-1:0] tag,
                                                         input int unsigned set_idx,
                                                         input logic [ADDR_WIDTH-1:0] low);
    logic [95:0] wide;
    int          sb;
    sb   = eff_set_bits();
    wide = {48'b0, tag};
    wide = (wide << sb) | (set_idx & ((1 << sb) - 1));
    wide = (wide << cfg_offset_bits) | ({48'b0, low} & ((96'd1 << cfg_offset_bits) - 1));
    return wide[ADDR_WIDTH-1:0];
  endfunction

  // Look the address up in the model set, reorder it and advance the totals
  task automatic lru_lookup(input logic cmd, input logic [ADDR_WIDTH-1:0] addr,
                            output access_result_t res);
    int                    sb;
    int                    cap;
    int                    fill;
    int                    pos;
    int                    keep;
    int                    set_idx;
    logic [ADDR_WIDTH-1:0] upper;
    logic [ADDR_WIDTH-1:0] tag;
    bit                    found;
    sb      = eff_set_bits();
    cap     = eff_ways();
    upper   = addr >> cfg_offset_bits;
    set_idx = int'(upper[SET_W-1:0]) & ((1 << sb) - 1);
    tag     = upper >> sb;
    fill    = set_fill[set_idx];
    if (fill > cap) fill = cap;
    found = 1'b0;
    pos   = 0;
    // Only the ways in use are searched, most recent first
    for (int i = 0; i < fill; i++) begin
      if (!found && line_ok[set_idx][i] && tag_mem[set_idx][i] == tag) begin
        found = 1'b1;
        pos   = i;
      end
    end
    if (found) begin
      for (int i = pos; i > 0; i--) tag_mem[set_idx][i] = tag_mem[set_idx][i-1];
      tag_mem[set_idx][0] = tag;
      hit_count   = hit_count + 1;
      res.outcome = OUT_HIT;
    end else begin
      if (fill < cap) begin
        keep        = fill;
        fill        = fill + 1;
        res.outcome = OUT_MISS;
      end else begin
        keep        = cap - 1;
        fill        = cap;
        res.outcome = OUT_EVICT;
        evict_count = evict_count + 1;
      end
      for (int i = keep; i > 0; i--) tag_mem[set_idx][i] = tag_mem[set_idx][i-1];
      tag_mem[set_idx][0] = tag;
      miss_count = miss_count + 1;
      // Drop lines beyond the way count
      for (int i = 0; i < MAX_WAYS; i++) line_ok[set_idx][i] = (i < fill);
      set_fill[set_idx] = fill;
    end
    // The store half of a modify always hits
    if (cmd) hit_count = hit_count + 1;
    res.extra_hit = cmd;
    res.hits      = hit_count;
    res.misses    = miss_count;
    res.evictions = evict_count;
  endtask

  task automatic check_field(input string name, input logic [31:0] want_val,
                             input logic [31:0] got_val);
    if (got_val !== want_val) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want_val, got_val);
    end
  endtask

  // Compare each accepted result with the oldest prediction
  always @(posedge clk_i) begin : result_check
    access_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_outcomes.size() == 0) begin
        errors++;
        $display("%0t: result with none expected, outcome %0d hits %0d misses %0d",
                 $time, outcome_o, hit_total_o, miss_total_o);
      end else begin
        want = pending_outcomes.pop_front();
        check_field("outcome", 32'(want.outcome), 32'(outcome_o));
        check_field("extra_hit", 32'(want.extra_hit), 32'(extra_hit_o));
        check_field("hit_total", want.hits, hit_total_o);
        check_field("miss_total", want.misses, miss_total_o);
        check_field("eviction_total", want.evictions, eviction_total_o);
        results_seen++;
      end
    end
  end

  // End the run if it hangs
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("set_assoc_lru_cache_sim_core verification failed");
    $finish;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  // Send one request and record its predicted result on acceptance
  task automatic send_access(input logic cmd, input logic [ADDR_WIDTH-1:0] addr);
    int unsigned    gap;
    access_result_t res;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i      <= cmd;
    address_i  <= addr;
    do @(posedge clk_i); while (in_stall_o);
    lru_lookup(cmd, addr, res);
    pending_outcomes.push_back(res);
    items_sent++;
  endtask

  // Drop valid and wait for every predicted result to drain
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write one register; valid stays high for the caller to drop
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_SET_BITS:    cfg_set_bits    = value[2:0];
      CFG_OFFSET_BITS: cfg_offset_bits = value[4:0];
      CFG_WAYS_IN_USE: cfg_ways        = value[3:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  // Reprogram the geometry once the core is idle
  task automatic configure(input logic [CFG_DATA_W-1:0] sb, input logic [CFG_DATA_W-1:0] off,
                           input logic [CFG_DATA_W-1:0] ways);
    wait_idle();
    write_reg(CFG_SET_BITS, sb);
    write_reg(CFG_OFFSET_BITS, off);
    write_reg(CFG_WAYS_IN_USE, ways);
    write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
    cfg_valid_i <= 1'b0;
  endtask

  // Reset geometry, basic LRU order and a way count lowered under live lines
  task automatic test_lru_order();
    send_access(1'b0, '0);
    send_access(1'b1, '0);
    send_access(1'b0, '1);
    send_access(1'b1, compose_addr(48'd1, 0, 48'h7));
    send_access(1'b0, '0);
    configure(5'd4, 5'd4, 5'd2);
    send_access(1'b0, compose_addr(48'd2, 0, '0));
    send_access(1'b0, compose_addr(48'd0, 0, 48'h3));
    send_access(1'b1, compose_addr(48'd3, 0, '0));
    send_access(1'b0, compose_addr(48'd2, 0, '0));
    configure(5'd4, 5'd4, 5'd4);
    for (int t = 10; t < 14; t++) send_access(1'b0, compose_addr(48'(t), 5, '0));
    // Way 2 still holds a tag but is no longer searched
    configure(5'd4, 5'd4, 5'd2);
    send_access(1'b0, compose_addr(48'd11, 5, '0));
    send_access(1'b0, compose_addr(48'd13, 5, '0));
  endtask

  // Register extremes: saturated set width, widest offsets, out-of-range ways
  task automatic test_register_corners();
    configure(5'd7, 5'd16, 5'd0);
    send_access(1'b0, '1);
    send_access(1'b1, '1);
    configure(5'd0, 5'd31, 5'd15);
    send_access(1'b0, 48'h8000_0000_0000);
    send_access(1'b0, 48'h7FFF_FFFF_FFFF);
    configure(5'd6, 5'd0, 5'd31);
    send_access(1'b0, 48'h0000_0000_003F);
    send_access(1'b1, 48'h0000_0000_003F);
    send_access(1'b0, 48'h0000_0000_0040);
  endtask

  // Random phases: reused tags in a few sets, with random addresses as noise
  task automatic test_random_traffic();
    logic [ADDR_WIDTH-1:0] tags [TAG_POOL];
    logic [ADDR_WIDTH-1:0] addr;
    logic [CFG_DATA_W-1:0] sb;
    logic [CFG_DATA_W-1:0] off;
    logic [CFG_DATA_W-1:0] ways;
    int unsigned           set_base;
    int unsigned           span;
    int unsigned           r;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      sb = (phase == 0) ? 5'd0 : (phase == 1) ? 5'd7 : CFG_DATA_W'($urandom_range(0, 7));
      r  = $urandom_range(0, 9);
      off = (r == 0) ? 5'd0 : (r == 1) ? 5'd16 : (r == 2) ? 5'd31
                                               : CFG_DATA_W'($urandom_range(0, 12));
      ways = (phase == 2) ? 5'd8 : (phase == 4) ? 5'd1 : CFG_DATA_W'($urandom_range(0, 31));
      configure(sb, off, ways);
      calm = (phase == 3 || phase == 8);
      for (int i = 0; i < TAG_POOL; i++) tags[i] = ADDR_WIDTH'({$urandom, $urandom});
      set_base = $urandom;
      span     = (eff_ways() + 1 < TAG_POOL) ? eff_ways() + 1 : TAG_POOL - 1;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(0, 99) < 15) begin
          addr = ADDR_WIDTH'({$urandom, $urandom});
        end else begin
          addr = compose_addr(tags[$urandom_range(0, span)], set_base + $urandom_range(0, 2),
                              ADDR_WIDTH'({$urandom, $urandom}));
        end
        send_access(1'($urandom), addr);
      end
      calm = 1'b0;
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_lru_order();
    test_register_corners();
    test_random_traffic();
    wait_idle();
    $display("Run covered %0d requests and %0d checked results over %0d register writes.",
             items_sent, results_seen, reg_writes);
    $display("Final totals: %0d hits, %0d misses, %0d evictions.",
             hit_count, miss_count, evict_count);
    if (errors == 0) begin
      $display("set_assoc_lru_cache_sim_core verification clean");
    end else begin
      $display("set_assoc_lru_cache_sim_core verification failed");
    end
    $finish;
  end

endmodule
